// ===== hw/rtl/tlut_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_pkg
// Types and constants shared by the taint label union table and its store.
// ----------------------------------------------------------------------------
package tlut_pkg;

    localparam int LABEL_W = 6;
    localparam int VEC_W   = 64;

    typedef logic [LABEL_W-1:0] t_label;
    typedef logic [VEC_W-1:0]   t_vec;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_UNION  = 2'd1,
        CMD_SUBSET = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // label handed out when no slot is left
    localparam t_label OVERFLOW_LABEL = 6'd1;
    // fixed contents of entry 1: base colour 1
    localparam t_vec   BASE1_VEC      = 64'h2;

    typedef struct packed {
        logic [1:0] cmd;
        t_label     label_a;
        t_label     label_b;
    } t_in_item;

    typedef struct packed {
        t_label     result_label;
        logic       flag;
        logic [1:0] status;
        t_label     label_total;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic   en;
        t_label addr;
    } t_tbl_rd;

    typedef struct packed {
        logic   en;
        t_label addr;
        t_vec   data;
    } t_tbl_wr;

    function automatic t_out_item mk_res(t_label lbl, logic flag, logic [1:0] status,
                                         t_label total, logic last);
        t_out_item r;
        r.result_label = lbl;
        r.flag         = flag;
        r.status       = status;
        r.label_total  = total;
        r.last         = last;
        return r;
    endfunction

endpackage

// ===== hw/rtl/tlut_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_table
// Label vector store: one write port, one registered read port. Entries 0
// and 1 are never written and read as their fixed values.
// ----------------------------------------------------------------------------
module tlut_table
    import tlut_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic    i_clk,
    input  t_tbl_rd i_rd,
    input  t_tbl_wr i_wr,
    output t_vec    o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    t_vec   mem [DEPTH];
    t_vec   r_rd_data;
    t_label r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr[AW-1:0]];
            r_rd_addr <= i_rd.addr;
        end
    end

    always_comb begin
        if (r_rd_addr == '0) begin
            o_rd_data = '0;
        end else if (r_rd_addr == t_label'(1)) begin
            o_rd_data = BASE1_VEC;
        end else begin
            o_rd_data = r_rd_data;
        end
    end

endmodule

// ===== hw/rtl/taint_label_union_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taint_label_union_table
// Taint label table with create, union, subset test and base-label listing.
// ----------------------------------------------------------------------------
// One command is in flight at a time; the input stalls until its last result
// is in the output register. Create, invalid operands and union fast paths
// are settled in decode; subset reads both operand entries. A union that
// searches compares entries from entry 0 upward, at most the label count
// before the command plus one: the search reads one table entry per cycle
// through the single read port. List scans colour bits up to the highest set
// one and, for each set colour, compares entries from the previous base label
// up to the match; an empty label gives a single result.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module taint_label_union_table
    import tlut_pkg::*;
#(
    parameter int NUM_LABEL_SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [LABEL_W:0] SLOTS = (LABEL_W+1)'(NUM_LABEL_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_B,
        ST_OPB,
        ST_SCAN,
        ST_SRCH,
        ST_EMIT
    } t_state;

    t_state    r_state, n_state;
    t_cmd      r_cmd, n_cmd;
    t_label    r_a, n_a;
    t_label    r_b, n_b;
    t_label    r_lc, n_lc;
    t_label    r_cc, n_cc;
    t_vec      r_vec, n_vec;
    t_vec      r_target, n_target;
    t_label    r_c, n_c;
    t_label    r_cur, n_cur;
    t_label    r_pidx, n_pidx;
    t_out_item r_res, n_res;
    logic      r_ov, n_ov;
    t_out_item r_out, n_out;

    t_tbl_rd tbl_rd;
    t_tbl_wr tbl_wr;
    t_vec    tbl_q;

    logic   slot_free;
    logic   full;
    t_label lc_inc;
    t_label cc_inc;
    logic   hit;
    logic   list_last;

    tlut_table #(
        .DEPTH (NUM_LABEL_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd      (tbl_rd),
        .i_wr      (tbl_wr),
        .o_rd_data (tbl_q)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    assign slot_free = !r_ov || !i_out_stall;
    assign full      = ({1'b0, r_lc} + (LABEL_W+1)'(1)) >= SLOTS;
    assign lc_inc    = r_lc + t_label'(1);
    assign cc_inc    = r_cc + t_label'(1);
    assign hit       = (tbl_q == r_target);
    assign list_last = (r_vec[VEC_W-1:1] == '0);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_a      = r_a;
        n_b      = r_b;
        n_lc     = r_lc;
        n_cc     = r_cc;
        n_vec    = r_vec;
        n_target = r_target;
        n_c      = r_c;
        n_cur    = r_cur;
        n_pidx   = r_pidx;
        n_res    = r_res;
        n_ov     = r_ov && i_out_stall;
        n_out    = r_out;
        tbl_rd   = '0;
        tbl_wr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_in_item.cmd);
                    n_a     = i_in_item.label_a;
                    n_b     = i_in_item.label_b;
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_state = ST_EMIT;
                if (r_cmd == CMD_CREATE) begin
                    if (full) begin
                        n_res = mk_res(OVERFLOW_LABEL, 1'b0, STATUS_FULL, r_lc, 1'b1);
                    end else begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.addr = lc_inc;
                        tbl_wr.data = t_vec'(1) << cc_inc;
                        n_cc        = cc_inc;
                        n_lc        = lc_inc;
                        n_res       = mk_res(lc_inc, 1'b0, STATUS_OK, lc_inc, 1'b1);
                    end
                end else if (r_a > r_lc || (r_cmd != CMD_LIST && r_b > r_lc)) begin
                    n_res = mk_res('0, 1'b0, STATUS_INVALID, r_lc, 1'b1);
                end else if (r_cmd == CMD_UNION && r_a == '0) begin
                    n_res = mk_res(r_b, 1'b0, STATUS_OK, r_lc, 1'b1);
                end else if (r_cmd == CMD_UNION && (r_b == '0 || r_a == r_b)) begin
                    n_res = mk_res(r_a, 1'b0, STATUS_OK, r_lc, 1'b1);
                end else begin
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_a;
                    n_state     = ST_RD_B;
                end
            end

            ST_RD_B: begin
                n_vec = tbl_q;
                if (r_cmd == CMD_LIST) begin
                    n_c     = '0;
                    n_cur   = '0;
                    n_state = ST_SCAN;
                end else begin
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_b;
                    n_state     = ST_OPB;
                end
            end

            ST_OPB: begin
                if (r_cmd == CMD_UNION) begin
                    n_target    = r_vec | tbl_q;
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = '0;
                    n_pidx      = '0;
                    n_state     = ST_SRCH;
                end else begin
                    n_res   = mk_res('0, ((tbl_q & ~r_vec) == '0), STATUS_OK, r_lc, 1'b1);
                    n_state = ST_EMIT;
                end
            end

            ST_SCAN: begin
                if (r_vec == '0) begin
                    // label with no colours
                    n_res   = mk_res('0, 1'b0, STATUS_OK, r_lc, 1'b1);
                    n_state = ST_EMIT;
                end else if (r_vec[0]) begin
                    n_target    = t_vec'(1) << r_c;
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_cur;
                    n_pidx      = r_cur;
                    n_state     = ST_SRCH;
                end else begin
                    n_vec = r_vec >> 1;
                    n_c   = r_c + t_label'(1);
                end
            end

            ST_SRCH: begin
                // tbl_q holds entry r_pidx; next read is issued alongside
                if (hit || r_pidx == r_lc) begin
                    n_state = ST_EMIT;
                    if (r_cmd == CMD_UNION) begin
                        if (hit) begin
                            n_res = mk_res(r_pidx, 1'b0, STATUS_OK, r_lc, 1'b1);
                        end else if (full) begin
                            n_res = mk_res(OVERFLOW_LABEL, 1'b0, STATUS_FULL, r_lc, 1'b1);
                        end else begin
                            tbl_wr.en   = 1'b1;
                            tbl_wr.addr = lc_inc;
                            tbl_wr.data = r_target;
                            n_lc        = lc_inc;
                            n_res       = mk_res(lc_inc, 1'b0, STATUS_OK, lc_inc, 1'b1);
                        end
                    end else begin
                        if (hit) begin
                            n_cur = r_pidx;
                            n_res = mk_res(r_pidx, 1'b1, STATUS_OK, r_lc, list_last);
                        end else begin
                            n_res = mk_res('0, 1'b0, STATUS_OK, r_lc, list_last);
                        end
                        n_vec = r_vec >> 1;
                        n_c   = r_c + t_label'(1);
                    end
                end else begin
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_pidx + t_label'(1);
                    n_pidx      = r_pidx + t_label'(1);
                end
            end

            ST_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = r_res.last ? ST_IDLE : ST_SCAN;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lc    <= t_label'(1);
            r_cc    <= t_label'(1);
            r_ov    <= 1'b0;
            r_out   <= '0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_cc    <= n_cc;
            r_ov    <= n_ov;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_vec    <= n_vec;
        r_target <= n_target;
        r_c      <= n_c;
        r_cur    <= n_cur;
        r_pidx   <= n_pidx;
        r_res    <= n_res;
    end

endmodule

// ===== bench/tb_taint_label_union_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_taint_label_union_table
// Self-checking bench for the taint label union table. A short directed run
// covers each command and corner case, then random commands follow under
// bursty input traffic and patterned output back-pressure. A label-set model
// in the scoreboard predicts every result transfer and checks it field by
// field in order.
// ----------------------------------------------------------------------------
module tb_taint_label_union_table
    import tlut_pkg::*;
();

    localparam int NUM_SLOTS = 64;
    localparam int HOLD_CYCLES = 400;

    class label_scoreboard;
        t_vec      label_sets[NUM_SLOTS];
        int        label_count;
        int        colour_count;
        t_out_item pending_results[$];
        int        errors;

        function new();
            foreach (label_sets[i]) label_sets[i] = '0;
            label_sets[1] = BASE1_VEC;
            label_count   = 1;
            colour_count  = 1;
            errors        = 0;
        endfunction

        function void add_expected(int lbl, logic flag, logic [1:0] status, logic last);
            t_out_item r;
            r.result_label = t_label'(lbl);
            r.flag         = flag;
            r.status       = status;
            r.label_total  = t_label'(label_count);
            r.last         = last;
            pending_results.push_back(r);
        endfunction

        function int append_set(t_vec v, logic fresh, output logic full);
            full = (label_count + 1 >= NUM_SLOTS);
            if (full) return OVERFLOW_LABEL;
            if (fresh) begin
                colour_count = (colour_count + 1) & 63;
                v = t_vec'(1) << colour_count;
            end
            label_count++;
            label_sets[label_count] = v;
            return label_count;
        endfunction

        // Works out every result that one accepted command produces.
        function void note_command(t_in_item it);
            t_cmd   op;
            int     a, b, lbl, found, cur, top;
            t_vec   merged, one_hot;
            logic   full;
            op   = t_cmd'(it.cmd);
            a    = it.label_a;
            b    = it.label_b;
            full = 1'b0;
            if (op == CMD_CREATE) begin
                lbl = append_set('0, 1'b1, full);
                add_expected(lbl, 1'b0, full ? STATUS_FULL : STATUS_OK, 1'b1);
            end else if (a > label_count || (op != CMD_LIST && b > label_count)) begin
                add_expected(0, 1'b0, STATUS_INVALID, 1'b1);
            end else begin
                case (op)
                    CMD_UNION: begin
                        if (a == 0) begin
                            lbl = b;
                        end else if (b == 0 || a == b) begin
                            lbl = a;
                        end else begin
                            merged = label_sets[a] | label_sets[b];
                            lbl    = -1;
                            for (int i = 0; i <= label_count; i++)
                                if (lbl < 0 && label_sets[i] == merged) lbl = i;
                            if (lbl < 0) lbl = append_set(merged, 1'b0, full);
                        end
                        add_expected(lbl, 1'b0, full ? STATUS_FULL : STATUS_OK, 1'b1);
                    end
                    CMD_SUBSET: begin
                        add_expected(0, (label_sets[b] & ~label_sets[a]) == '0, STATUS_OK,
                                     1'b1);
                    end
                    default: begin
                        merged = label_sets[a];
                        top    = -1;
                        cur    = 0;
                        for (int c = 0; c < 64; c++)
                            if (merged[c]) top = c;
                        if (top < 0) begin
                            add_expected(0, 1'b0, STATUS_OK, 1'b1);
                        end else begin
                            // base labels are searched from the last one found upwards
                            for (int c = 0; c <= top; c++) begin
                                if (merged[c]) begin
                                    one_hot = t_vec'(1) << c;
                                    found   = -1;
                                    for (int i = cur; i <= label_count; i++)
                                        if (found < 0 && label_sets[i] == one_hot) found = i;
                                    if (found < 0) begin
                                        add_expected(0, 1'b0, STATUS_OK, c == top);
                                    end else begin
                                        cur = found;
                                        add_expected(found, 1'b1, STATUS_OK, c == top);
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: label %0d flag %0d status %0d",
                       got.result_label, got.flag, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_label !== want.result_label) begin
                $error("result_label: expected %0d, got %0d", want.result_label,
                       got.result_label);
                errors++;
            end
            if (got.flag !== want.flag) begin
                $error("flag: expected %0d, got %0d", want.flag, got.flag);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.label_total !== want.label_total) begin
                $error("label_total: expected %0d, got %0d", want.label_total,
                       got.label_total);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b1;
    t_out_item out_item;

    label_scoreboard sb = new();

    int burst_left  = 0;
    int hold_epoch  = 0;
    int seen_epoch  = 0;
    int hold_left   = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int cycle_no    = 0;

    taint_label_union_table #(
        .NUM_LABEL_SLOTS(NUM_SLOTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("tb_taint_label_union_table: FAIL");
        $finish;
    end

    // Output side: check each transfer, then choose next cycle's stall.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
        cycle_no <= cycle_no + 1;
        if (hold_epoch != seen_epoch) begin
            seen_epoch <= hold_epoch;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                2:       out_stall <= (cycle_no % 4 == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    function automatic t_in_item cmd_item(t_cmd c, int a, int b);
        t_in_item it;
        it.cmd     = c;
        it.label_a = t_label'(a);
        it.label_b = t_label'(b);
        return it;
    endfunction

    function automatic t_label pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return t_label'($urandom_range(0, 63));
        if (r < 15) return '0;
        return t_label'($urandom_range(0, sb.label_count));
    endfunction

    function automatic t_in_item random_command();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 18)      it.cmd = CMD_CREATE;
        else if (r < 55) it.cmd = CMD_UNION;
        else if (r < 70) it.cmd = CMD_SUBSET;
        else             it.cmd = CMD_LIST;
        it.label_a = pick_label();
        it.label_b = ($urandom_range(0, 9) == 0) ? it.label_a : pick_label();
        return it;
    endfunction

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        in_item  <= t_in_item'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_command(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(it);
    endtask

    // Bursts of back-to-back transfers separated by random gaps.
    task automatic offer(input t_in_item it);
        send_command(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 10));
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    initial begin
        t_in_item directed[$];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(cmd_item(CMD_LIST, 1, 0));
        directed.push_back(cmd_item(CMD_LIST, 0, 0));      // empty set
        directed.push_back(cmd_item(CMD_SUBSET, 0, 0));
        directed.push_back(cmd_item(CMD_CREATE, 0, 0));
        directed.push_back(cmd_item(CMD_CREATE, 63, 63));  // operands ignored
        directed.push_back(cmd_item(CMD_CREATE, 0, 0));
        directed.push_back(cmd_item(CMD_UNION, 2, 3));     // appends
        directed.push_back(cmd_item(CMD_UNION, 3, 2));     // found by search
        directed.push_back(cmd_item(CMD_UNION, 0, 4));
        directed.push_back(cmd_item(CMD_UNION, 4, 0));
        directed.push_back(cmd_item(CMD_UNION, 3, 3));
        directed.push_back(cmd_item(CMD_UNION, 5, 4));
        directed.push_back(cmd_item(CMD_SUBSET, 6, 5));
        directed.push_back(cmd_item(CMD_SUBSET, 5, 6));
        directed.push_back(cmd_item(CMD_LIST, 6, 0));
        directed.push_back(cmd_item(CMD_LIST, 63, 0));     // invalid operand
        directed.push_back(cmd_item(CMD_UNION, 63, 1));
        directed.push_back(cmd_item(CMD_UNION, 1, 63));
        directed.push_back(cmd_item(CMD_SUBSET, 2, 63));
        directed.push_back(cmd_item(CMD_LIST, 2, 63));     // label_b unused by list
        directed.push_back(cmd_item(CMD_UNION, 1, 6));
        directed.push_back(cmd_item(CMD_LIST, 7, 0));
        directed.push_back(cmd_item(CMD_UNION, 2, 5));
        foreach (directed[i]) offer(directed[i]);

        for (int k = 0; k < 300; k++) begin
            if (k == 90) hold_epoch <= hold_epoch + 1;
            if (k == 180) wait_drained();
            offer(random_command());
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_taint_label_union_table: PASS");
        end else begin
            $display("tb_taint_label_union_table: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tlut_pkg.sv
hw/rtl/tlut_table.sv
hw/rtl/taint_label_union_table.sv
bench/tb_taint_label_union_table.sv
